// ----- rtl/lrs_pkg.sv -----
package lrs_pkg;

	localparam int MAX_ITEMS   = 64;
	localparam int VALUE_BITS  = 20;
	localparam int FIELD_BITS  = 20;
	localparam int RADIX       = 10;
	localparam int DIGIT_BITS  = 4;
	localparam int AW          = $clog2(MAX_ITEMS);
	localparam int CW          = $clog2(MAX_ITEMS + 1);
	// q / 10 == (q * 0xCCCCCCCD) >> 35 for every 32-bit q
	localparam logic [63:0] RECIP_10 = 64'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [DIGIT_BITS-1:0] digit_t;
	typedef logic [CW-1:0]         count_t;

	// one chain position: the value and what is left of it above the current place
	typedef struct packed {
		logic   vld;
		value_t value;
		value_t quot;
	} entry_t;

	typedef struct packed {
		value_t value;
		value_t quot;
	} slot_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] item_value;
		logic                  is_final;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] sorted_value;
		logic                  end_of_run;
		logic                  overflowed;
	} out_item_t;

endpackage

// ----- rtl/lrs_cell.sv -----
module lrs_cell import lrs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift_en,
	input  entry_t d,
	output entry_t q
);

	logic   vld_q;
	value_t value_q;
	value_t quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (shift_en) begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			value_q <= d.value;
			quot_q  <= d.quot;
		end
	end

	assign q = '{vld: vld_q, value: value_q, quot: quot_q};

endmodule

// ----- rtl/lrs_digit.sv -----
module lrs_digit import lrs_pkg::*; (
	input  value_t quot,
	output digit_t digit,
	output value_t quot_next
);

	logic [63:0] prod;
	value_t      rem;

	always_comb begin
		prod      = 64'(quot) * RECIP_10;
		quot_next = VALUE_BITS'(prod >> RECIP_SHIFT);
		// quot - 10 * quot_next, never below zero
		rem       = quot - (quot_next << 3) - (quot_next << 1);
		digit     = rem[DIGIT_BITS-1:0];
	end

endmodule

// ----- rtl/lsd_decimal_radix_sort.sv -----
// Loading: one item per cycle, no stall while collecting.
// After the final item: one count sweep per pass plus a closing count sweep, each pass
// being count + prefix + place + copy over the cell row.
// One pass is run per decimal digit of the largest value; results then leave at up to one
// per cycle while result_stall is low, and the output walks the whole cell row.
// Reset clears the state, cell valid bits, bucket counts and flags; the stores are not cleared.
module lsd_decimal_radix_sort import lrs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_COUNT,
		S_PREFIX,
		S_PLACE,
		S_COPY,
		S_OUTPUT
	} state_t;

	localparam count_t LAST_STEP = CW'(MAX_ITEMS - 1);
	localparam count_t FULL      = CW'(MAX_ITEMS);
	localparam count_t LAST_BKT  = CW'(RADIX - 1);

	state_t    state_q;
	count_t    step_q;
	count_t    n_q;
	count_t    emit_q;
	count_t    run_q;
	logic      ovf_q;
	logic      any_nz_q;
	count_t    bkt_q [RADIX];
	logic      result_valid_q;
	out_item_t result_q;

	logic      rd_vld_s1;
	logic      rd_keep_s1;
	slot_t     rd_data_s1;
	slot_t     scratch [MAX_ITEMS];

	entry_t    chain [MAX_ITEMS];
	entry_t    head;
	entry_t    tail_d;
	logic      shift_en;
	value_t    load_v;
	digit_t    digit;
	value_t    quot_next;
	count_t    slot_ptr;
	logic      out_take;
	logic      nz_now;

	assign head   = chain[0];
	assign load_v = VALUE_BITS'(item.item_value);

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
			entry_t cell_d;
			if (gi == MAX_ITEMS - 1) begin : g_tail
				assign cell_d = tail_d;
			end else begin : g_mid
				assign cell_d = chain[gi + 1];
			end
			lrs_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(shift_en),
				.d       (cell_d),
				.q       (chain[gi])
			);
		end
	endgenerate

	lrs_digit u_digit (
		.quot     (head.quot),
		.digit    (digit),
		.quot_next(quot_next)
	);

	always_comb begin
		slot_ptr = '0;
		for (int j = 0; j < RADIX; j++) begin
			if (digit == DIGIT_BITS'(j)) begin
				slot_ptr = bkt_q[j];
			end
		end
	end

	assign out_take = !head.vld || !result_valid_q || !result_stall;
	assign nz_now   = any_nz_q || (head.vld && (head.quot != '0));

	always_comb begin
		shift_en = 1'b0;
		tail_d   = '0;
		case (state_q)
			S_LOAD: begin
				shift_en = item_valid && (n_q < FULL);
				tail_d   = '{vld: 1'b1, value: load_v, quot: load_v};
			end
			S_COUNT, S_PLACE: begin
				shift_en = 1'b1;
				tail_d   = head;
			end
			S_COPY: begin
				shift_en = rd_vld_s1;
				tail_d   = '{vld: rd_keep_s1, value: rd_data_s1.value, quot: rd_data_s1.quot};
			end
			S_OUTPUT: begin
				shift_en = out_take;
			end
			default: begin
				shift_en = 1'b0;
			end
		endcase
	end

	// scratch store: placement writes, copy-back reads
	always_ff @(posedge clk) begin
		if (state_q == S_PLACE && head.vld) begin
			scratch[slot_ptr[AW-1:0]] <= '{value: head.value, quot: quot_next};
		end
		if (state_q == S_COPY) begin
			rd_data_s1 <= scratch[step_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			step_q         <= '0;
			n_q            <= '0;
			emit_q         <= '0;
			run_q          <= '0;
			ovf_q          <= 1'b0;
			any_nz_q       <= 1'b0;
			rd_vld_s1      <= 1'b0;
			rd_keep_s1     <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			for (int j = 0; j < RADIX; j++) begin
				bkt_q[j] <= '0;
			end
		end else begin
			rd_vld_s1 <= (state_q == S_COPY) && (step_q < FULL);
			if (state_q == S_OUTPUT && out_take && head.vld) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (item_valid) begin
						if (n_q < FULL) begin
							n_q <= n_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.is_final) begin
							state_q  <= S_COUNT;
							step_q   <= '0;
							any_nz_q <= 1'b0;
							for (int j = 0; j < RADIX; j++) begin
								bkt_q[j] <= '0;
							end
						end
					end
				end
				S_COUNT: begin
					if (head.vld) begin
						for (int j = 0; j < RADIX; j++) begin
							if (digit == DIGIT_BITS'(j)) begin
								bkt_q[j] <= bkt_q[j] + 1'b1;
							end
						end
					end
					any_nz_q <= nz_now;
					if (step_q == LAST_STEP) begin
						step_q  <= '0;
						run_q   <= '0;
						// every remaining quotient zero: no more digits to sort on
						state_q <= nz_now ? S_PREFIX : S_OUTPUT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_PREFIX: begin
					// rotate counts out of the bottom, bucket starts in at the top
					for (int j = 0; j < RADIX - 1; j++) begin
						bkt_q[j] <= bkt_q[j + 1];
					end
					bkt_q[RADIX-1] <= run_q;
					run_q          <= run_q + bkt_q[0];
					if (step_q == LAST_BKT) begin
						step_q  <= '0;
						state_q <= S_PLACE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_PLACE: begin
					if (head.vld) begin
						for (int j = 0; j < RADIX; j++) begin
							if (digit == DIGIT_BITS'(j)) begin
								bkt_q[j] <= bkt_q[j] + 1'b1;
							end
						end
					end
					if (step_q == LAST_STEP) begin
						step_q  <= '0;
						state_q <= S_COPY;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_COPY: begin
					if (step_q < FULL) begin
						rd_keep_s1 <= step_q < n_q;
						step_q     <= step_q + 1'b1;
					end else begin
						step_q   <= '0;
						any_nz_q <= 1'b0;
						state_q  <= S_COUNT;
						for (int j = 0; j < RADIX; j++) begin
							bkt_q[j] <= '0;
						end
					end
				end
				S_OUTPUT: begin
					if (out_take) begin
						if (head.vld) begin
							result_q <= '{sorted_value: FIELD_BITS'(head.value),
							              end_of_run:   emit_q == (n_q - 1'b1),
							              overflowed:   ovf_q};
						end
						if (step_q == LAST_STEP) begin
							step_q  <= '0;
							n_q     <= '0;
							emit_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							step_q <= step_q + 1'b1;
							if (head.vld) begin
								emit_q <= emit_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign item_stall   = state_q != S_LOAD;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= FULL)
		else $error("item count beyond capacity");

	a_place_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE && head.vld) |-> (slot_ptr < n_q))
		else $error("placement pointer past the held items");

	a_last_bucket_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE && step_q == LAST_STEP) |=> (bkt_q[RADIX-1] == n_q))
		else $error("bucket fill does not account for every item");

endmodule

// ----- bench/tb_lsd_decimal_radix_sort.sv -----
`timescale 1ns / 1ps

module tb_lsd_decimal_radix_sort;
	import lrs_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int LONG_HOLD   = 2000;

	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t res;
	} row_t;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_item_t  item;
	logic      result_valid;
	logic      result_stall;
	out_item_t result;

	// model of the sorter: values held so far and the results still owed
	value_t    held_values[$];
	value_t    held_peak;
	bit        held_dropped;
	out_item_t sorted_due[$];

	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned rx_taken = 0;
	int unsigned hold_asks = 0;
	bit          tx_burst = 1'b0;
	logic [FIELD_BITS-1:0] last_value = '0;
	out_item_t   want;

	// single-value sets carry their result in the row
	row_t plan [0:20] = '{
		'{'{20'd0, 1'b1}, 1'b1, '{20'd0, 1'b1, 1'b0}},
		'{'{20'hFFFFF, 1'b1}, 1'b1, '{20'hFFFFF, 1'b1, 1'b0}},
		'{'{20'd5, 1'b0}, 1'b0, '0},
		'{'{20'd0, 1'b0}, 1'b0, '0},
		'{'{20'd0, 1'b0}, 1'b0, '0},
		'{'{20'd3, 1'b1}, 1'b0, '0},
		'{'{20'd0, 1'b0}, 1'b0, '0},
		'{'{20'd0, 1'b0}, 1'b0, '0},
		'{'{20'd0, 1'b1}, 1'b0, '0},
		'{'{20'd1048575, 1'b0}, 1'b0, '0},
		'{'{20'd999999, 1'b0}, 1'b0, '0},
		'{'{20'd1000000, 1'b0}, 1'b0, '0},
		'{'{20'd9, 1'b0}, 1'b0, '0},
		'{'{20'd10, 1'b0}, 1'b0, '0},
		'{'{20'd100, 1'b0}, 1'b0, '0},
		'{'{20'd524288, 1'b1}, 1'b0, '0},
		'{'{20'h55555, 1'b0}, 1'b0, '0},
		'{'{20'hAAAAA, 1'b1}, 1'b0, '0},
		'{'{20'd7, 1'b0}, 1'b0, '0},
		'{'{20'd70, 1'b0}, 1'b0, '0},
		'{'{20'd7, 1'b1}, 1'b0, '0}
	};

	lsd_decimal_radix_sort dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// store one value; on the final item run the decimal passes and queue the run
	task automatic load_and_sort(input in_item_t it, input bit typed, input out_item_t typed_res);
		value_t      v;
		value_t      rest;
		value_t      scratch [MAX_ITEMS];
		int unsigned tally [RADIX];
		int unsigned start [RADIX];
		int unsigned passes, place, run, d, n;
		out_item_t   r;
		v = it.item_value[VALUE_BITS-1:0];
		if (held_values.size() < MAX_ITEMS) begin
			held_values.push_back(v);
			if (v > held_peak)
				held_peak = v;
		end else begin
			held_dropped = 1'b1;
		end
		if (!it.is_final)
			return;
		passes = 0;
		for (rest = held_peak; rest != 0; rest = VALUE_BITS'(rest / RADIX))
			passes++;
		place = 1;
		repeat (passes) begin
			for (d = 0; d < RADIX; d++)
				tally[d] = 0;
			foreach (held_values[i])
				tally[(held_values[i] / place) % RADIX]++;
			run = 0;
			for (d = 0; d < RADIX; d++) begin
				start[d] = run;
				run += tally[d];
			end
			foreach (held_values[i]) begin
				d = (held_values[i] / place) % RADIX;
				scratch[start[d]] = held_values[i];
				start[d]++;
			end
			foreach (held_values[i])
				held_values[i] = scratch[i];
			place *= RADIX;
		end
		n = held_values.size();
		foreach (held_values[i]) begin
			r.sorted_value = FIELD_BITS'(held_values[i]);
			r.end_of_run   = (i == n - 1);
			r.overflowed   = held_dropped;
			sorted_due.push_back(typed ? typed_res : r);
		end
		held_values.delete();
		held_peak    = '0;
		held_dropped = 1'b0;
	endtask

	task automatic offer_item(input in_item_t it, input bit typed, input out_item_t typed_res);
		int unsigned gap;
		gap = tx_burst ? 0 : $urandom_range(0, 5);
		repeat (gap) @(negedge clk);
		item       = it;
		item_valid = 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		load_and_sort(it, typed, typed_res);
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (sorted_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [FIELD_BITS-1:0] draw_value();
		int unsigned k;
		case ($urandom_range(0, 5))
			0: draw_value = FIELD_BITS'($urandom_range(0, 9));
			1: draw_value = FIELD_BITS'($urandom_range(0, 999));
			2: draw_value = FIELD_BITS'($urandom_range(0, 99999));
			3: draw_value = FIELD_BITS'($urandom & 32'hFFFFF);
			4: begin
				k = $urandom_range(0, 6);
				draw_value = FIELD_BITS'(10 ** k - $urandom_range(0, 1));
			end
			default: draw_value = last_value;
		endcase
		last_value = draw_value;
	endfunction

	// receiver: a per-item wait, quiet stretches, and one long hold on request
	initial begin
		int unsigned wait_left, hold_left, rx_seen, holds_taken;
		wait_left   = 0;
		hold_left   = 0;
		rx_seen     = 0;
		holds_taken = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asks != holds_taken) begin
				holds_taken = hold_asks;
				hold_left   = LONG_HOLD;
			end
			if (rx_taken != rx_seen) begin
				rx_seen   = rx_taken;
				wait_left = ((rx_seen / 40) % 4 == 3) ? 0 : $urandom_range(0, 5);
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall = 1'b1;
			end else if (wait_left > 0) begin
				wait_left--;
				result_stall = 1'b1;
			end else begin
				result_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			rx_taken++;
			if (sorted_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected item: value %0d end %0b ovf %0b", $time,
					result.sorted_value, result.end_of_run, result.overflowed);
			end else begin
				want = sorted_due.pop_front();
				if (result.sorted_value !== want.sorted_value) begin
					mismatches++;
					$display("%0t: sorted_value expected %0d got %0d", $time,
						want.sorted_value, result.sorted_value);
				end
				if (result.end_of_run !== want.end_of_run) begin
					mismatches++;
					$display("%0t: end_of_run expected %0b got %0b", $time,
						want.end_of_run, result.end_of_run);
				end
				if (result.overflowed !== want.overflowed) begin
					mismatches++;
					$display("%0t: overflowed expected %0b got %0b", $time,
						want.overflowed, result.overflowed);
				end
			end
		end
	end

	initial begin
		in_item_t    it;
		int unsigned sent, set_no, size, pick;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		held_peak    = '0;
		held_dropped = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i])
			offer_item(plan[i].stim, plan[i].typed, plan[i].res);
		wait_drained();

		sent   = 0;
		set_no = 0;
		while (sent < 310) begin
			if (set_no == 2) begin
				size = MAX_ITEMS;
			end else if (set_no == 5) begin
				size = MAX_ITEMS + 6;  // last six dropped, final among them
			end else begin
				pick = $urandom_range(0, 19);
				if (pick < 12)
					size = $urandom_range(1, 8);
				else if (pick < 18)
					size = $urandom_range(9, 40);
				else if (pick == 18)
					size = $urandom_range(56, 64);
				else
					size = $urandom_range(65, 72);
			end
			tx_burst = (set_no % 5 == 3) || (set_no >= 8 && set_no <= 10);
			if (set_no == 8) begin
				// results back up behind the held receiver while items keep coming
				@(posedge clk);
				hold_asks++;
				@(negedge clk);
			end
			if (set_no == 14)
				wait_drained();
			for (int k = 0; k < size; k++) begin
				it.item_value = draw_value();
				it.is_final   = (k == size - 1);
				offer_item(it, 1'b0, '0);
				sent++;
			end
			set_no++;
		end

		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
